FILE: hdl/coo_csr_pkg.sv
// ----------------------------------------------------------------------------
// COO to CSR converter package
// Field widths, action and status codes, and the control and status groups
// that pass between the controller and the datapath.
// ----------------------------------------------------------------------------
package coo_csr_pkg;

  localparam int ACT_W  = 2;
  localparam int ROW_W  = 8;
  localparam int COL_W  = 16;
  localparam int VAL_W  = 32;
  localparam int IDX_W  = 9;
  localparam int SLOT_W = 12;
  localparam int PTR_W  = 13;
  localparam int STAT_W = 2;

  localparam int MAX_ROWS_DEF    = 256;
  localparam int MAX_ENTRIES_DEF = 4096;

  localparam logic [IDX_W-1:0] ROWS_RESET = 9'd256;

  typedef enum logic [ACT_W-1:0] {
    ACT_ADD   = 2'd0,
    ACT_READ  = 2'd1,
    ACT_CLEAR = 2'd2,
    ACT_NOP   = 2'd3
  } action_e;

  typedef enum logic [STAT_W-1:0] {
    STS_OK        = 2'd0,
    STS_ROW_RANGE = 2'd1,
    STS_FULL      = 2'd2,
    STS_IDX_RANGE = 2'd3
  } status_e;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic capture;    // take the input item and work out its immediate result
    logic add_write;  // write back the incremented row count
    logic sum_run;    // step the row pointer summation
    logic out_load;   // move the finished result into the output register
  } ctrl_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    action_e act;       // decoded action of the offered item
    logic    add_ok;    // offered add is in range and the store has room
    logic    idx_ok;    // offered pointer index is in range
    logic    sum_done;  // summation has finished
    logic    out_free;  // output register can take a result this cycle
  } dp_stat_t;

endpackage

FILE: hdl/coo_csr_ram.sv
// ----------------------------------------------------------------------------
// Generic RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module coo_csr_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

FILE: hdl/coo_csr_ctrl.sv
// ----------------------------------------------------------------------------
// COO to CSR controller
// Sequences one item at a time: capture, count update or summation, and the
// hand-off of the result to the output register.
// ----------------------------------------------------------------------------
module coo_csr_ctrl (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   in_valid_i,
  output logic                   in_stall_o,
  input  coo_csr_pkg::dp_stat_t  stat_i,
  output coo_csr_pkg::ctrl_cmd_t cmd_o
);

  typedef enum logic [1:0] {
    S_IDLE,
    S_ADD_WR,
    S_SUM,
    S_DONE
  } state_e;

  state_e state_q, state_d;

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_o.capture = 1'b1;
          state_d       = S_DONE;
          if (stat_i.act == coo_csr_pkg::ACT_ADD && stat_i.add_ok) begin
            state_d = S_ADD_WR;
          end else if (stat_i.act == coo_csr_pkg::ACT_READ && stat_i.idx_ok) begin
            state_d = S_SUM;
          end
        end
      end
      S_ADD_WR: begin
        cmd_o.add_write = 1'b1;
        state_d         = S_DONE;
      end
      S_SUM: begin
        cmd_o.sum_run = 1'b1;
        if (stat_i.sum_done) begin
          state_d = S_DONE;
        end
      end
      S_DONE: begin
        if (stat_i.out_free) begin
          cmd_o.out_load = 1'b1;
          state_d        = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  assign in_stall_o = (state_q != S_IDLE);

endmodule

FILE: hdl/coo_csr_dp.sv
// ----------------------------------------------------------------------------
// COO to CSR datapath
// Row count RAM with per-row valid bits, entry counter, row pointer
// accumulator, result registers and the output register.
// ----------------------------------------------------------------------------
module coo_csr_dp #(
  parameter int MAX_ROWS    = coo_csr_pkg::MAX_ROWS_DEF,
  parameter int MAX_ENTRIES = coo_csr_pkg::MAX_ENTRIES_DEF
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                cfg_we_i,
  input  logic [coo_csr_pkg::IDX_W-1:0]       cfg_wdata_i,
  input  logic [coo_csr_pkg::ACT_W-1:0]       action_i,
  input  logic [coo_csr_pkg::ROW_W-1:0]       entry_row_i,
  input  logic [coo_csr_pkg::COL_W-1:0]       entry_col_i,
  input  logic [coo_csr_pkg::VAL_W-1:0]       entry_value_i,
  input  logic [coo_csr_pkg::IDX_W-1:0]       pointer_index_i,
  output logic                                out_valid_o,
  input  logic                                out_stall_i,
  output logic [coo_csr_pkg::SLOT_W-1:0]      slot_o,
  output logic [coo_csr_pkg::COL_W-1:0]       out_col_o,
  output logic [coo_csr_pkg::VAL_W-1:0]       out_value_o,
  output logic [coo_csr_pkg::PTR_W-1:0]       row_pointer_o,
  output logic [coo_csr_pkg::STAT_W-1:0]      status_o,
  input  coo_csr_pkg::ctrl_cmd_t              cmd_i,
  output coo_csr_pkg::dp_stat_t               stat_o
);

  localparam int AW = $clog2(MAX_ROWS);

  // Configuration and effective row count.
  logic [coo_csr_pkg::IDX_W-1:0] rows_q;
  logic [coo_csr_pkg::IDX_W-1:0] n_rows;

  // Counting state.
  logic [MAX_ROWS-1:0]           valid_q;
  logic [coo_csr_pkg::PTR_W-1:0] entry_count_q;

  // Item and summation state.
  logic [AW-1:0]                 row_q;
  logic [AW-1:0]                 rd_addr_q;
  logic [coo_csr_pkg::IDX_W-1:0] idx_q;
  logic [coo_csr_pkg::IDX_W-1:0] k_q;
  logic                          pend_q;

  // Result registers.
  logic [coo_csr_pkg::SLOT_W-1:0] res_slot_q;
  logic [coo_csr_pkg::COL_W-1:0]  res_col_q;
  logic [coo_csr_pkg::VAL_W-1:0]  res_val_q;
  logic [coo_csr_pkg::PTR_W-1:0]  res_ptr_q;
  coo_csr_pkg::status_e           res_sts_q;

  // Output register.
  logic                           out_valid_q;
  logic [coo_csr_pkg::SLOT_W-1:0] out_slot_q;
  logic [coo_csr_pkg::COL_W-1:0]  out_col_q;
  logic [coo_csr_pkg::VAL_W-1:0]  out_val_q;
  logic [coo_csr_pkg::PTR_W-1:0]  out_ptr_q;
  logic [coo_csr_pkg::STAT_W-1:0] out_sts_q;

  // RAM signals.
  logic                          ram_re;
  logic [AW-1:0]                 ram_raddr;
  logic [coo_csr_pkg::PTR_W-1:0] ram_rdata;
  logic [coo_csr_pkg::PTR_W-1:0] cur_count;

  coo_csr_pkg::action_e act;
  logic row_ok;
  logic not_full;
  logic idx_ok;
  logic issue;

  // A register value of zero acts as one row; values above the store depth clamp.
  always_comb begin
    if (rows_q == '0) begin
      n_rows = coo_csr_pkg::IDX_W'(1);
    end else if (32'(rows_q) > 32'(MAX_ROWS)) begin
      n_rows = coo_csr_pkg::IDX_W'(MAX_ROWS);
    end else begin
      n_rows = rows_q;
    end
  end

  assign act      = coo_csr_pkg::action_e'(action_i);
  assign row_ok   = coo_csr_pkg::IDX_W'(entry_row_i) < n_rows;
  assign not_full = 32'(entry_count_q) < 32'(MAX_ENTRIES);
  assign idx_ok   = pointer_index_i <= n_rows;
  assign issue    = (k_q != idx_q);

  // A row never written since the last clear reads as zero.
  assign cur_count = valid_q[rd_addr_q] ? ram_rdata : '0;

  assign ram_re    = cmd_i.capture || (cmd_i.sum_run && issue);
  assign ram_raddr = cmd_i.sum_run ? AW'(k_q) : AW'(entry_row_i);

  coo_csr_ram #(
    .WIDTH (coo_csr_pkg::PTR_W),
    .DEPTH (MAX_ROWS)
  ) u_count_ram (
    .clk_i   (clk_i),
    .we_i    (cmd_i.add_write),
    .waddr_i (row_q),
    .wdata_i (cur_count + coo_csr_pkg::PTR_W'(1)),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rows_q        <= coo_csr_pkg::ROWS_RESET;
      valid_q       <= '0;
      entry_count_q <= '0;
      k_q           <= '0;
      pend_q        <= 1'b0;
      out_valid_q   <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        rows_q <= cfg_wdata_i;
      end
      if (cmd_i.capture) begin
        k_q    <= '0;
        pend_q <= 1'b0;
        if (act == coo_csr_pkg::ACT_CLEAR) begin
          valid_q       <= '0;
          entry_count_q <= '0;
        end
      end
      if (cmd_i.add_write) begin
        valid_q[row_q] <= 1'b1;
        entry_count_q  <= entry_count_q + coo_csr_pkg::PTR_W'(1);
      end
      if (cmd_i.sum_run) begin
        pend_q <= issue;
        if (issue) begin
          k_q <= k_q + coo_csr_pkg::IDX_W'(1);
        end
      end
      if (cmd_i.out_load) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (ram_re) begin
      rd_addr_q <= ram_raddr;
    end
    if (cmd_i.capture) begin
      row_q      <= AW'(entry_row_i);
      idx_q      <= pointer_index_i;
      res_slot_q <= '0;
      res_col_q  <= '0;
      res_val_q  <= '0;
      res_ptr_q  <= '0;
      res_sts_q  <= coo_csr_pkg::STS_OK;
      case (act)
        coo_csr_pkg::ACT_ADD: begin
          if (!row_ok) begin
            res_sts_q <= coo_csr_pkg::STS_ROW_RANGE;
          end else if (!not_full) begin
            res_sts_q <= coo_csr_pkg::STS_FULL;
          end else begin
            res_slot_q <= entry_count_q[coo_csr_pkg::SLOT_W-1:0];
            res_col_q  <= entry_col_i;
            res_val_q  <= entry_value_i;
          end
        end
        coo_csr_pkg::ACT_READ: begin
          if (!idx_ok) begin
            res_sts_q <= coo_csr_pkg::STS_IDX_RANGE;
          end
        end
        default: begin
        end
      endcase
    end
    // Reads are issued one row per cycle and each is summed in the cycle after its read.
    if (cmd_i.sum_run && pend_q) begin
      res_ptr_q <= res_ptr_q + cur_count;
    end
    if (cmd_i.out_load) begin
      out_slot_q <= res_slot_q;
      out_col_q  <= res_col_q;
      out_val_q  <= res_val_q;
      out_ptr_q  <= res_ptr_q;
      out_sts_q  <= res_sts_q;
    end
  end

  always_comb begin
    stat_o.act      = act;
    stat_o.add_ok   = row_ok && not_full;
    stat_o.idx_ok   = idx_ok;
    stat_o.sum_done = !issue && !pend_q;
    stat_o.out_free = !out_valid_q || !out_stall_i;
  end

  assign out_valid_o   = out_valid_q;
  assign slot_o        = out_slot_q;
  assign out_col_o     = out_col_q;
  assign out_value_o   = out_val_q;
  assign row_pointer_o = out_ptr_q;
  assign status_o      = out_sts_q;

endmodule

FILE: hdl/coo_to_csr_row_pointer_builder_unit.sv
// ----------------------------------------------------------------------------
// COO to CSR row pointer builder
// Counts row-sorted COO entries per row, hands out CSR slots and answers row
// pointer queries.
// ----------------------------------------------------------------------------
// The block takes one item at a time and gives one result for each. An add
// is captured, its row count is written back in the add-write state, and the
// result then moves into the output register. A clear, an unused action or a
// rejected item moves straight from capture to the output register. A row
// pointer read of index i walks the per-row counts in a single-read-port RAM
// one row per cycle over rows 0 to i - 1 and sums each count as its read data
// returns, before its result moves on. The input is free again in the cycle
// the result appears, so a new item is taken only once the last one is done.
// A stalled output delays the move into the output register by the length of
// the stall. A clear takes effect at once through per-row valid bits, so no
// clearing pass follows reset or a clear.
// ----------------------------------------------------------------------------
module coo_to_csr_row_pointer_builder_unit #(
  parameter int MAX_ROWS    = coo_csr_pkg::MAX_ROWS_DEF,
  parameter int MAX_ENTRIES = coo_csr_pkg::MAX_ENTRIES_DEF
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_we_i,
  input  logic [coo_csr_pkg::IDX_W-1:0]  cfg_wdata_i,
  input  logic                           in_valid_i,
  output logic                           in_stall_o,
  input  logic [coo_csr_pkg::ACT_W-1:0]  action_i,
  input  logic [coo_csr_pkg::ROW_W-1:0]  entry_row_i,
  input  logic [coo_csr_pkg::COL_W-1:0]  entry_col_i,
  input  logic [coo_csr_pkg::VAL_W-1:0]  entry_value_i,
  input  logic [coo_csr_pkg::IDX_W-1:0]  pointer_index_i,
  output logic                           out_valid_o,
  input  logic                           out_stall_i,
  output logic [coo_csr_pkg::SLOT_W-1:0] slot_o,
  output logic [coo_csr_pkg::COL_W-1:0]  out_col_o,
  output logic [coo_csr_pkg::VAL_W-1:0]  out_value_o,
  output logic [coo_csr_pkg::PTR_W-1:0]  row_pointer_o,
  output logic [coo_csr_pkg::STAT_W-1:0] status_o
);

  coo_csr_pkg::ctrl_cmd_t cmd;
  coo_csr_pkg::dp_stat_t  stat;

  coo_csr_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .stat_i     (stat),
    .cmd_o      (cmd)
  );

  coo_csr_dp #(
    .MAX_ROWS    (MAX_ROWS),
    .MAX_ENTRIES (MAX_ENTRIES)
  ) u_dp (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_we_i        (cfg_we_i),
    .cfg_wdata_i     (cfg_wdata_i),
    .action_i        (action_i),
    .entry_row_i     (entry_row_i),
    .entry_col_i     (entry_col_i),
    .entry_value_i   (entry_value_i),
    .pointer_index_i (pointer_index_i),
    .out_valid_o     (out_valid_o),
    .out_stall_i     (out_stall_i),
    .slot_o          (slot_o),
    .out_col_o       (out_col_o),
    .out_value_o     (out_value_o),
    .row_pointer_o   (row_pointer_o),
    .status_o        (status_o),
    .cmd_i           (cmd),
    .stat_o          (stat)
  );

endmodule
